// ----- rtl/tick_task_dispatcher_top_defines.svh -----
// ----------------------------------------------------------------------------
// Tick task dispatcher assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef TICK_TASK_DISPATCHER_TOP_DEFINES_SVH
`define TICK_TASK_DISPATCHER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTD_ASSERT(lbl, prop, msg)
`define TTD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/ttd_pkg.sv -----
// ----------------------------------------------------------------------------
// Tick task dispatcher package
// Item types, opcodes, controller states and the cell control bundle.
// ----------------------------------------------------------------------------
package ttd_pkg;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;
  localparam logic [1:0] OP_REPORT = 2'd3;

  localparam logic KIND_DISPATCH = 1'b0;
  localparam logic KIND_PASS_END = 1'b1;

  localparam logic [4:0] SPARE_WRAP = 5'd31;
  localparam logic [4:0] SPARE_HALF = 5'd16;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  entry_index;
    logic [15:0] run_period;
    logic [15:0] budget_micros;
    logic [15:0] pass_budget;
    logic [31:0] used_micros;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  task_index;
    logic [31:0] spare_time_sum;
    logic [4:0]  spare_pass_count;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic        shift;
    logic        stamp;
    logic [15:0] tick_count;
    logic [15:0] remaining;
    logic [15:0] interval;
    logic [15:0] budget;
  } cell_ctl_t;

endpackage

// ----- rtl/tick_task_dispatcher_top.sv -----
// Tick and load items are handled while idle. Start and resumed scans walk
// the token along the cell row one entry at a time and stop at the first due
// entry, or give a pass-end result when no entry is due; no new item is
// taken until the scan ends. A report that ends the pass emits from ST_DONE.
// Reset (rst_n low, synchronous) clears all task entries, counters and
// the spare accumulator; the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
// Tick task dispatcher top level
// Scan controller, spare accounting and a row of task cells.
// ----------------------------------------------------------------------------
`include "tick_task_dispatcher_top_defines.svh"

module tick_task_dispatcher_top #(
  parameter int MAX_TASKS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ttd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ttd_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);

  localparam int PW = $clog2(MAX_TASKS + 1);
  localparam int CW = (PW > 5) ? PW : 5;

  ttd_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [15:0]        tick_r, tick_nxt;
  logic [4:0]         act_r;
  logic               pass_r, pass_nxt;
  logic [31:0]        sum_r, sum_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  ttd_pkg::out_item_t out_data_r, out_data_nxt;

  ttd_pkg::cell_ctl_t ctl;
  logic               load;
  logic [MAX_TASKS-1:0] tok;
  logic [MAX_TASKS-1:0] hit;
  logic [MAX_TASKS-1:0] load_en;

  logic          in_acc;
  logic          out_free;
  logic          any_hit;
  logic [CW-1:0] n_ext;
  logic          scan_end;
  logic [32:0]   sum_add;
  logic [31:0]   sum_pre;
  logic          finish;
  logic          emit;
  logic          emit_kind;

  assign in_stall  = (state_r != ttd_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign any_hit   = |hit;
  assign n_ext     = (CW'(act_r) > CW'(MAX_TASKS)) ? CW'(MAX_TASKS) : CW'(act_r);
  assign scan_end  = (pos_r >= n_ext);
  assign sum_add   = {1'b0, sum_r} + {17'd0, rem_r};

  genvar gi;
  generate
    for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
      assign load_en[gi] = load && ({28'd0, in_data.entry_index} == 32'(gi));
      if (gi == 0) begin : g_head
        ttd_cell #(.FIRST(1'b1)) u_cell (
          .clk(clk), .rst_n(rst_n), .ctl(ctl), .load_en(load_en[gi]),
          .tok_in(1'b0), .tok_out(tok[gi]), .hit(hit[gi])
        );
      end else begin : g_body
        ttd_cell #(.FIRST(1'b0)) u_cell (
          .clk(clk), .rst_n(rst_n), .ctl(ctl), .load_en(load_en[gi]),
          .tok_in(tok[gi-1]), .tok_out(tok[gi]), .hit(hit[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ttd_pkg::ST_IDLE: begin
        if (in_acc && in_data.opcode == ttd_pkg::OP_START) begin
          state_nxt = ttd_pkg::ST_SCAN;
        end else if (in_acc && in_data.opcode == ttd_pkg::OP_REPORT && pass_r) begin
          if (in_data.used_micros >= {16'd0, rem_r}) begin
            state_nxt = ttd_pkg::ST_DONE;
          end else begin
            state_nxt = ttd_pkg::ST_SCAN;
          end
        end
      end
      ttd_pkg::ST_SCAN: begin
        if ((scan_end || any_hit) && out_free) begin
          state_nxt = ttd_pkg::ST_IDLE;
        end
      end
      ttd_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = ttd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ttd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl            = '0;
    ctl.tick_count = tick_r;
    ctl.remaining  = rem_r;
    ctl.interval   = in_data.run_period;
    ctl.budget     = in_data.budget_micros;
    load           = 1'b0;
    pos_nxt        = pos_r;
    rem_nxt        = rem_r;
    tick_nxt       = tick_r;
    pass_nxt       = pass_r;
    sum_pre        = sum_r;
    finish         = 1'b0;
    emit           = 1'b0;
    emit_kind      = ttd_pkg::KIND_PASS_END;
    unique case (state_r)
      ttd_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_data.opcode)
            ttd_pkg::OP_TICK: tick_nxt = tick_r + 16'd1;
            ttd_pkg::OP_LOAD: load = 1'b1;
            ttd_pkg::OP_START: begin
              rem_nxt   = in_data.pass_budget;
              pos_nxt   = '0;
              pass_nxt  = 1'b0;
              ctl.start = 1'b1;
            end
            default: begin
              if (pass_r) begin
                ctl.stamp = 1'b1;
                if (in_data.used_micros >= {16'd0, rem_r}) begin
                  pass_nxt = 1'b0;
                end else begin
                  rem_nxt   = rem_r - in_data.used_micros[15:0];
                  pos_nxt   = pos_r + CW'(1);
                  ctl.shift = 1'b1;
                end
              end
            end
          endcase
        end
      end
      ttd_pkg::ST_SCAN: begin
        if (scan_end) begin
          if (out_free) begin
            sum_pre  = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
            pass_nxt = 1'b0;
            finish   = 1'b1;
            emit     = 1'b1;
          end
        end else if (any_hit) begin
          if (out_free) begin
            pass_nxt  = 1'b1;
            emit      = 1'b1;
            emit_kind = ttd_pkg::KIND_DISPATCH;
          end
        end else begin
          ctl.shift = 1'b1;
          pos_nxt   = pos_r + CW'(1);
        end
      end
      ttd_pkg::ST_DONE: begin
        if (out_free) begin
          finish = 1'b1;
          emit   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sum_nxt = sum_pre;
    cnt_nxt = cnt_r;
    if (finish) begin
      if (cnt_r == ttd_pkg::SPARE_WRAP) begin
        cnt_nxt = ttd_pkg::SPARE_HALF;
        sum_nxt = sum_pre >> 1;
      end else begin
        cnt_nxt = cnt_r + 5'd1;
      end
    end
    out_data_nxt = out_data_r;
    if (emit) begin
      out_data_nxt.result_kind      = emit_kind;
      out_data_nxt.task_index       = (emit_kind == ttd_pkg::KIND_DISPATCH) ? 4'(pos_r) : 4'd0;
      out_data_nxt.spare_time_sum   = sum_nxt;
      out_data_nxt.spare_pass_count = cnt_nxt;
    end
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttd_pkg::ST_IDLE;
      pos_r       <= '0;
      rem_r       <= '0;
      tick_r      <= '0;
      act_r       <= '0;
      pass_r      <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      rem_r       <= rem_nxt;
      tick_r      <= tick_nxt;
      pass_r      <= pass_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        act_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `TTD_ASSERT(a_tok_onehot0, $onehot0(tok), "more than one scan token in the cell row")
  `TTD_ASSERT(a_tok_scan, (state_r == ttd_pkg::ST_SCAN && !scan_end) |-> $onehot(tok), "scan token lost during scan")
  `TTD_ASSERT(a_tok_pass, (state_r == ttd_pkg::ST_IDLE && pass_r) |-> $onehot(tok), "dispatched task has no token")
  `TTD_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> (state_r == ttd_pkg::ST_IDLE && !out_valid_r), "not idle after reset")

endmodule

// ----- rtl/ttd_cell.sv -----
// ----------------------------------------------------------------------------
// Tick task dispatcher cell
// Holds one task entry and a scan token passed to the next cell.
// ----------------------------------------------------------------------------
module ttd_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ttd_pkg::cell_ctl_t ctl,
  input  logic              load_en,
  input  logic              tok_in,
  output logic              tok_out,
  output logic              hit
);

  logic [15:0] interval_r, interval_nxt;
  logic [15:0] budget_r, budget_nxt;
  logic [15:0] last_r, last_nxt;
  logic        tok_r, tok_nxt;
  logic [15:0] elapsed;

  assign elapsed = ctl.tick_count - last_r;
  assign hit     = tok_r && (elapsed >= interval_r) && (budget_r <= ctl.remaining);
  assign tok_out = tok_r;

  always_comb begin
    interval_nxt = load_en ? ctl.interval : interval_r;
    budget_nxt   = load_en ? ctl.budget : budget_r;
    last_nxt     = (ctl.stamp && tok_r) ? ctl.tick_count : last_r;
    if (ctl.start) begin
      tok_nxt = FIRST;
    end else if (ctl.shift) begin
      tok_nxt = tok_in;
    end else begin
      tok_nxt = tok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= '0;
      budget_r   <= '0;
      last_r     <= '0;
      tok_r      <= 1'b0;
    end else begin
      interval_r <= interval_nxt;
      budget_r   <= budget_nxt;
      last_r     <= last_nxt;
      tok_r      <= tok_nxt;
    end
  end

endmodule
